[design/assert_macros.svh]
// Assertion macros shared by the tangent frame design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/ttf_pkg.sv]
// Types and constants shared by the tangent frame pipeline.
`timescale 1ns / 1ps
`default_nettype none

package ttf_pkg;

   localparam int COMPONENT_BITS = 16;
   localparam int FRAC_BITS      = COMPONENT_BITS - 2;
   // Raw vector components: products of two unit values and their differences.
   localparam int RAW_W          = 2 * FRAC_BITS + 3;
   localparam int MAG_W          = RAW_W - 1;
   localparam int SH_W           = $clog2(MAG_W);
   localparam int SQ_W           = 2 * MAG_W;
   localparam int LEN_W          = SQ_W + 2;
   localparam int ROOT_W         = MAG_W + 1;
   localparam int SQ_STEPS       = MAG_W + 1;
   localparam int SQ_STAGES      = (SQ_STEPS + 1) / 2;
   localparam int Q_W            = FRAC_BITS + 1;
   localparam int NUM_W          = MAG_W + FRAC_BITS + 2;
   localparam int DIV_STAGES     = (Q_W + 1) / 2;
   localparam int UNIT_LAT       = SQ_STAGES + DIV_STAGES + 6;
   localparam int UNIT_ONE       = 1 << FRAC_BITS;
   localparam int DEGEN_THR      = ((1 << (2 * FRAC_BITS)) + 999999) / 1000000;

   typedef logic [2:0][RAW_W-1:0]          raw3_type;
   typedef logic [2:0][COMPONENT_BITS-1:0] vec3_type;
   typedef logic [1:0][COMPONENT_BITS-1:0] uv2_type;

endpackage

`default_nettype wire

[design/ttf_unit.sv]
// Pipelined unit-length scaler for one three-component vector.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ttf_unit
   import ttf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  logic     in_valid,
   input  raw3_type in_vec,
   output logic     out_valid,
   output vec3_type out_vec
);

   typedef struct packed {
      logic       valid;
      logic [2:0] neg;
      logic       zero;
   } tag_type;

   typedef struct packed {
      logic [LEN_W-1:0] x;
      logic [LEN_W-1:0] r;
   } root_type;

   typedef struct packed {
      logic [NUM_W-1:0] n;
      logic [Q_W-1:0]   q;
   } dv_type;

   function automatic root_type root_step(root_type a, int k);
      root_type         b;
      logic [LEN_W-1:0] bitv;
      logic [LEN_W-1:0] trial;
      bitv  = LEN_W'(1) << (2 * k);
      trial = a.r + bitv;
      if (a.x >= trial) begin
         b.x = a.x - trial;
         b.r = (a.r >> 1) + bitv;
      end else begin
         b.x = a.x;
         b.r = a.r >> 1;
      end
      return b;
   endfunction

   function automatic dv_type div_step(dv_type a, logic [ROOT_W-1:0] d, int k);
      dv_type           b;
      logic [NUM_W-1:0] trial;
      trial = NUM_W'(d) << k;
      b     = a;
      if (a.n >= trial) begin
         b.n = a.n - trial;
         b.q = a.q | (Q_W'(1) << k);
      end
      return b;
   endfunction

   tag_type           tag_ff [UNIT_LAT];
   logic [MAG_W-1:0]  mag0_in [3];
   logic [2:0]        neg0_in;
   logic [MAG_W-1:0]  mag0_ff [3];
   logic [SH_W-1:0]   sh;
   logic              zero1;
   logic [MAG_W-1:0]  mc_ff [SQ_STAGES+3][3];
   logic [SQ_W-1:0]   sq_ff [3];
   root_type          root_in [SQ_STAGES];
   root_type          root_ff [SQ_STAGES+1];
   dv_type            dv_in [DIV_STAGES][3];
   dv_type            dv_ff [DIV_STAGES+1][3];
   logic [ROOT_W-1:0] dsr_ff [DIV_STAGES+1];
   vec3_type          out_ff;

   // Magnitudes and signs.
   always_comb begin
      logic [RAW_W-1:0] abs_v;
      abs_v = '0;
      for (int i = 0; i < 3; i++) begin
         neg0_in[i] = in_vec[i][RAW_W-1];
         abs_v      = neg0_in[i] ? (~in_vec[i] + 1'b1) : in_vec[i];
         mag0_in[i] = abs_v[MAG_W-1:0];
      end
   end

   // The leading one of the OR of the magnitudes is that of the largest one.
   always_comb begin
      logic [MAG_W-1:0] orv;
      logic [SH_W-1:0]  msb;
      orv = mag0_ff[0] | mag0_ff[1] | mag0_ff[2];
      msb = '0;
      for (int b = 0; b < MAG_W; b++) begin
         if (orv[b]) begin
            msb = SH_W'(b);
         end
      end
      sh    = SH_W'(MAG_W - 1) - msb;
      zero1 = (orv == '0);
   end

   for (genvar st = 0; st < SQ_STAGES; st++) begin : g_root
      localparam int K0 = SQ_STEPS - 1 - 2 * st;
      localparam int K1 = K0 - 1;
      always_comb begin
         root_type t;
         t = root_step(root_ff[st], K0);
         if (K1 >= 0) begin
            t = root_step(t, K1);
         end
         root_in[st] = t;
      end
   end

   for (genvar st = 0; st < DIV_STAGES; st++) begin : g_div
      localparam int K0 = Q_W - 1 - 2 * st;
      localparam int K1 = K0 - 1;
      for (genvar i = 0; i < 3; i++) begin : g_comp
         always_comb begin
            dv_type t;
            t = div_step(dv_ff[st][i], dsr_ff[st], K0);
            if (K1 >= 0) begin
               t = div_step(t, dsr_ff[st], K1);
            end
            dv_in[st][i] = t;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < UNIT_LAT; p++) begin
            tag_ff[p] <= '0;
         end
      end else if (adv) begin
         tag_ff[0] <= '{valid: in_valid, neg: neg0_in, zero: 1'b0};
         tag_ff[1] <= '{valid: tag_ff[0].valid, neg: tag_ff[0].neg, zero: zero1};
         for (int p = 2; p < UNIT_LAT; p++) begin
            tag_ff[p] <= tag_ff[p-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            mag0_ff[i]  <= mag0_in[i];
            mc_ff[0][i] <= MAG_W'(mag0_ff[i] << sh);
            sq_ff[i]    <= SQ_W'(mc_ff[0][i]) * SQ_W'(mc_ff[0][i]);
         end
         for (int j = 1; j < SQ_STAGES + 3; j++) begin
            mc_ff[j] <= mc_ff[j-1];
         end
         root_ff[0].x <= LEN_W'(sq_ff[0]) + LEN_W'(sq_ff[1]) + LEN_W'(sq_ff[2]);
         root_ff[0].r <= '0;
         for (int st = 0; st < SQ_STAGES; st++) begin
            root_ff[st+1] <= root_in[st];
         end
         // Rounded quotient: add half the divisor to the scaled magnitude.
         dsr_ff[0] <= ROOT_W'(root_ff[SQ_STAGES].r);
         for (int i = 0; i < 3; i++) begin
            dv_ff[0][i].n <= (NUM_W'(mc_ff[SQ_STAGES+2][i]) << FRAC_BITS)
                             + NUM_W'(root_ff[SQ_STAGES].r >> 1);
            dv_ff[0][i].q <= '0;
         end
         for (int st = 0; st < DIV_STAGES; st++) begin
            dsr_ff[st+1] <= dsr_ff[st];
            dv_ff[st+1]  <= dv_in[st];
         end
         for (int i = 0; i < 3; i++) begin
            if (tag_ff[UNIT_LAT-2].zero) begin
               out_ff[i] <= '0;
            end else if (tag_ff[UNIT_LAT-2].neg[i]) begin
               out_ff[i] <= ~{1'b0, dv_ff[DIV_STAGES][i].q} + 1'b1;
            end else begin
               out_ff[i] <= {1'b0, dv_ff[DIV_STAGES][i].q};
            end
         end
      end
   end

   assign out_valid = tag_ff[UNIT_LAT-1].valid;
   assign out_vec   = out_ff;

   `ASSERT_IMPLY(a_zero_stays_zero, clock, reset, out_valid && tag_ff[UNIT_LAT-1].zero, out_vec == '0, "zero vector did not scale to zero")
   `ASSERT_IMPLY(a_nonzero_scales, clock, reset, out_valid && !tag_ff[UNIT_LAT-1].zero, out_vec != '0, "non-zero vector scaled to zero")
   `ASSERT_NEXT(a_hold_when_frozen, clock, reset, !adv, $stable(out_valid) && $stable(out_vec), "scaler output moved while frozen")

endmodule

`default_nettype wire

[design/triangle_tangent_frame_core.sv]
// Throughput: one word per cycle unless stalled; the depth comes from two passes
// through the unit scaler (square root and division, two bits a stage, 30 stages per pass).
// The pipeline stalls only when its last stage holds a word and the output
// register is full and stalled. Reset is synchronous and clears all valid bits.
// Top level of the per-corner tangent frame pipeline.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module triangle_tangent_frame_core
   import ttf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [47:0] req_corner_position,
   input  logic [47:0] req_next_position,
   input  logic [47:0] req_third_position,
   input  logic [31:0] req_corner_uv,
   input  logic [31:0] req_next_uv,
   input  logic [31:0] req_third_uv,
   input  logic [47:0] req_corner_normal,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [47:0] rsp_tangent_vec,
   output logic [47:0] rsp_bitangent_vec,
   output logic        rsp_flipped,
   output logic        rsp_degenerate
);

   localparam int PROD_W = 2 * COMPONENT_BITS;
   localparam int XD_W   = PROD_W + 1;
   localparam int CR_W   = XD_W - FRAC_BITS + 1;
   localparam int DP_W   = CR_W + COMPONENT_BITS;
   localparam int DS_W   = DP_W + 2;

   logic adv;
   logic out_en;

   vec3_type pc, pn, pt, nrm_in;
   uv2_type  uc, un, ut;

   logic     a_valid_ff;
   raw3_type a_vec_in [4];
   raw3_type a_vec_ff [4];
   vec3_type a_nrm_ff;

   logic [3:0] u1_valid;
   vec3_type   u1_vec [4];
   vec3_type   n1_ff [UNIT_LAT];

   logic                     b_valid_ff;
   logic signed [PROD_W-1:0] b_pdet_ff [2];
   logic signed [PROD_W-1:0] b_pt1_ff [3], b_pt2_ff [3], b_pb1_ff [3], b_pb2_ff [3];
   vec3_type                 b_nrm_ff;

   logic             c_valid_ff;
   logic [RAW_W-1:0] c_det_ff;
   raw3_type         c_tr_ff, c_br_ff;
   vec3_type         c_nrm_ff;

   logic             d_valid_ff;
   logic             d_degen_in;
   raw3_type         d_tan_in, d_bdir_in;
   raw3_type         d_tan_ff, d_bdir_ff;
   logic             d_degen_ff;
   vec3_type         d_nrm_ff;

   logic [1:0] u2_valid;
   vec3_type   u2_vec [2];
   vec3_type   n2_ff [UNIT_LAT];
   logic       g2_ff [UNIT_LAT];

   logic                     e_valid_ff;
   logic signed [PROD_W-1:0] e_xp_ff [6];
   vec3_type                 e_tan_ff, e_bdir_ff;
   logic                     e_degen_ff;

   logic                   f_valid_ff;
   logic signed [XD_W-1:0] f_cx_ff [3];
   vec3_type               f_tan_ff, f_bdir_ff;
   logic                   f_degen_ff;

   logic                   g_valid_ff;
   logic signed [CR_W-1:0] g_cr_in [3];
   logic signed [CR_W-1:0] g_cr_ff [3];
   vec3_type               g_tan_ff, g_bdir_ff;
   logic                   g_degen_ff;

   logic                   h_valid_ff;
   logic signed [DP_W-1:0] h_dp_ff [3];
   logic signed [CR_W-1:0] h_cr_ff [3];
   vec3_type               h_tan_ff;
   logic                   h_degen_ff;

   logic                   flip_in;
   vec3_type               bit_in;
   logic                   rsp_valid_ff;
   vec3_type               rsp_tan_ff, rsp_bit_ff;
   logic                   rsp_flip_ff, rsp_degen_ff;

   // Everything moves unless a finished word would be pushed into a full,
   // stalled output register.
   assign adv       = !(h_valid_ff && rsp_valid_ff && rsp_stall);
   assign out_en    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   assign pc     = req_corner_position;
   assign pn     = req_next_position;
   assign pt     = req_third_position;
   assign nrm_in = req_corner_normal;
   assign uc     = req_corner_uv;
   assign un     = req_next_uv;
   assign ut     = req_third_uv;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_vec_in[0][i] = RAW_W'($signed(pn[i])) - RAW_W'($signed(pc[i]));
         a_vec_in[1][i] = RAW_W'($signed(pt[i])) - RAW_W'($signed(pc[i]));
      end
      for (int i = 0; i < 2; i++) begin
         a_vec_in[2][i] = RAW_W'($signed(un[i])) - RAW_W'($signed(uc[i]));
         a_vec_in[3][i] = RAW_W'($signed(ut[i])) - RAW_W'($signed(uc[i]));
      end
      a_vec_in[2][2] = '0;
      a_vec_in[3][2] = '0;
   end

   for (genvar k = 0; k < 4; k++) begin : g_unit1
      ttf_unit u_unit (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (a_valid_ff),
         .in_vec    (a_vec_ff[k]),
         .out_valid (u1_valid[k]),
         .out_vec   (u1_vec[k])
      );
   end

   // The default frame is substituted before the second scaling pass, which
   // leaves an exact unit vector unchanged.
   always_comb begin
      logic [RAW_W-1:0] det_abs;
      logic             det_neg;
      det_neg    = c_det_ff[RAW_W-1];
      det_abs    = det_neg ? (~c_det_ff + 1'b1) : c_det_ff;
      d_degen_in = det_abs < RAW_W'(DEGEN_THR);
      for (int i = 0; i < 3; i++) begin
         if (d_degen_in) begin
            d_tan_in[i]  = (i == 0) ? RAW_W'(UNIT_ONE) : '0;
            d_bdir_in[i] = (i == 2) ? RAW_W'(UNIT_ONE) : '0;
         end else if (det_neg) begin
            d_tan_in[i]  = ~c_tr_ff[i] + 1'b1;
            d_bdir_in[i] = ~c_br_ff[i] + 1'b1;
         end else begin
            d_tan_in[i]  = c_tr_ff[i];
            d_bdir_in[i] = c_br_ff[i];
         end
      end
   end

   ttf_unit u_unit_tan (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (d_valid_ff),
      .in_vec    (d_tan_ff),
      .out_valid (u2_valid[0]),
      .out_vec   (u2_vec[0])
   );

   ttf_unit u_unit_bdir (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (d_valid_ff),
      .in_vec    (d_bdir_ff),
      .out_valid (u2_valid[1]),
      .out_vec   (u2_vec[1])
   );

   // Cross product rounded half away from zero.
   always_comb begin
      logic [XD_W-1:0] m;
      logic [XD_W-1:0] mr;
      m  = '0;
      mr = '0;
      for (int i = 0; i < 3; i++) begin
         m  = f_cx_ff[i][XD_W-1] ? (~f_cx_ff[i] + 1'b1) : f_cx_ff[i];
         mr = (m + XD_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
         g_cr_in[i] = f_cx_ff[i][XD_W-1] ? -$signed(mr[CR_W-1:0]) : $signed(mr[CR_W-1:0]);
      end
   end

   // Handedness test, negation and saturation.
   always_comb begin
      logic signed [DS_W-1:0] dot;
      logic signed [CR_W-1:0] crf;
      dot = DS_W'(h_dp_ff[0]) + DS_W'(h_dp_ff[1]) + DS_W'(h_dp_ff[2]);
      flip_in = dot[DS_W-1];
      crf = '0;
      for (int i = 0; i < 3; i++) begin
         crf = flip_in ? -h_cr_ff[i] : h_cr_ff[i];
         if (crf > CR_W'((1 << (COMPONENT_BITS - 1)) - 1)) begin
            bit_in[i] = COMPONENT_BITS'((1 << (COMPONENT_BITS - 1)) - 1);
         end else if (crf < -CR_W'(1 << (COMPONENT_BITS - 1))) begin
            bit_in[i] = COMPONENT_BITS'(1 << (COMPONENT_BITS - 1));
         end else begin
            bit_in[i] = crf[COMPONENT_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= u1_valid[0];
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= u2_valid[0];
         f_valid_ff <= e_valid_ff;
         g_valid_ff <= f_valid_ff;
         h_valid_ff <= g_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_vec_ff <= a_vec_in;
         a_nrm_ff <= nrm_in;

         n1_ff[0] <= a_nrm_ff;
         n2_ff[0] <= d_nrm_ff;
         g2_ff[0] <= d_degen_ff;
         for (int p = 1; p < UNIT_LAT; p++) begin
            n1_ff[p] <= n1_ff[p-1];
            n2_ff[p] <= n2_ff[p-1];
            g2_ff[p] <= g2_ff[p-1];
         end

         // Unit vectors: e1, e2, d1, d2.
         b_pdet_ff[0] <= $signed(u1_vec[2][0]) * $signed(u1_vec[3][1]);
         b_pdet_ff[1] <= $signed(u1_vec[2][1]) * $signed(u1_vec[3][0]);
         for (int i = 0; i < 3; i++) begin
            b_pt1_ff[i] <= $signed(u1_vec[0][i]) * $signed(u1_vec[3][1]);
            b_pt2_ff[i] <= $signed(u1_vec[1][i]) * $signed(u1_vec[2][1]);
            b_pb1_ff[i] <= $signed(u1_vec[1][i]) * $signed(u1_vec[2][0]);
            b_pb2_ff[i] <= $signed(u1_vec[0][i]) * $signed(u1_vec[3][0]);
         end
         b_nrm_ff <= n1_ff[UNIT_LAT-1];

         c_det_ff <= RAW_W'(b_pdet_ff[0] - b_pdet_ff[1]);
         for (int i = 0; i < 3; i++) begin
            c_tr_ff[i] <= RAW_W'(b_pt1_ff[i] - b_pt2_ff[i]);
            c_br_ff[i] <= RAW_W'(b_pb1_ff[i] - b_pb2_ff[i]);
         end
         c_nrm_ff <= b_nrm_ff;

         d_tan_ff   <= d_tan_in;
         d_bdir_ff  <= d_bdir_in;
         d_degen_ff <= d_degen_in;
         d_nrm_ff   <= c_nrm_ff;

         e_xp_ff[0] <= $signed(n2_ff[UNIT_LAT-1][1]) * $signed(u2_vec[0][2]);
         e_xp_ff[1] <= $signed(n2_ff[UNIT_LAT-1][2]) * $signed(u2_vec[0][1]);
         e_xp_ff[2] <= $signed(n2_ff[UNIT_LAT-1][2]) * $signed(u2_vec[0][0]);
         e_xp_ff[3] <= $signed(n2_ff[UNIT_LAT-1][0]) * $signed(u2_vec[0][2]);
         e_xp_ff[4] <= $signed(n2_ff[UNIT_LAT-1][0]) * $signed(u2_vec[0][1]);
         e_xp_ff[5] <= $signed(n2_ff[UNIT_LAT-1][1]) * $signed(u2_vec[0][0]);
         e_tan_ff   <= u2_vec[0];
         e_bdir_ff  <= u2_vec[1];
         e_degen_ff <= g2_ff[UNIT_LAT-1];

         for (int i = 0; i < 3; i++) begin
            f_cx_ff[i] <= XD_W'(e_xp_ff[2*i]) - XD_W'(e_xp_ff[2*i+1]);
         end
         f_tan_ff   <= e_tan_ff;
         f_bdir_ff  <= e_bdir_ff;
         f_degen_ff <= e_degen_ff;

         g_cr_ff    <= g_cr_in;
         g_tan_ff   <= f_tan_ff;
         g_bdir_ff  <= f_bdir_ff;
         g_degen_ff <= f_degen_ff;

         for (int i = 0; i < 3; i++) begin
            h_dp_ff[i] <= DP_W'(g_cr_ff[i]) * DP_W'($signed(g_bdir_ff[i]));
         end
         h_cr_ff    <= g_cr_ff;
         h_tan_ff   <= g_tan_ff;
         h_degen_ff <= g_degen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= h_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_tan_ff   <= h_tan_ff;
         rsp_bit_ff   <= bit_in;
         rsp_flip_ff  <= flip_in;
         rsp_degen_ff <= h_degen_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tangent_vec   = rsp_tan_ff;
   assign rsp_bitangent_vec = rsp_bit_ff;
   assign rsp_flipped       = rsp_flip_ff;
   assign rsp_degenerate    = rsp_degen_ff;

   `ASSERT_ALWAYS(a_unit1_lockstep, clock, reset, (u1_valid == '0) || (u1_valid == '1), "first scaler pass out of step")
   `ASSERT_ALWAYS(a_unit2_lockstep, clock, reset, (u2_valid == '0) || (u2_valid == '1), "second scaler pass out of step")
   `ASSERT_IMPLY(a_degen_frame, clock, reset, rsp_valid_ff && rsp_degen_ff, (rsp_tan_ff[0] == COMPONENT_BITS'(UNIT_ONE)) && (rsp_tan_ff[1] == '0) && (rsp_tan_ff[2] == '0), "degenerate word without default tangent")
   `ASSERT_NEXT(a_hold_on_stall, clock, reset, !adv, rsp_valid_ff, "output word lost during stall")

endmodule

`default_nettype wire

[tb/sv/triangle_tangent_frame_core_tb.sv]
// Testbench for the per-corner tangent frame pipeline, with a self-checking scoreboard.
`timescale 1ns / 1ps

module triangle_tangent_frame_core_tb
   import ttf_pkg::*;
();

   typedef struct {
      logic [47:0] corner_pos, next_pos, third_pos;
      logic [31:0] corner_uv, next_uv, third_uv;
      logic [47:0] normal;
   } corner_type;

   typedef struct packed {
      logic [47:0] tangent, bitangent;
      logic        flipped, degenerate;
   } frame_type;

   class frame_scoreboard_type;
      frame_type frames_due[$];
      int        mismatches;

      function longint comp(logic [47:0] w, int idx);
         logic [15:0] raw;
         raw = w[idx*16 +: 16];
         return longint'($signed(raw));
      endfunction

      function longint unsigned root_of(longint unsigned x);
         longint unsigned r, b;
         r = 0;
         b = 64'h4000_0000_0000_0000;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // Scales to the nearest unit vector in Q1.14; a zero vector stays zero.
      function void to_unit(input longint v[3], input int n, output longint o[3]);
         longint unsigned mag[3];
         longint unsigned big, len2, s, q;
         big = 0;
         len2 = 0;
         for (int i = 0; i < 3; i++) o[i] = 0;
         for (int i = 0; i < n; i++) begin
            mag[i] = v[i] < 0 ? longint'(-v[i]) : v[i];
            if (mag[i] > big) big = mag[i];
         end
         if (big == 0) return;
         while (big >= (64'd1 << 30)) begin
            big = big >> 1;
            for (int i = 0; i < n; i++) mag[i] = mag[i] >> 1;
         end
         while (big < (64'd1 << 29)) begin
            big = big << 1;
            for (int i = 0; i < n; i++) mag[i] = mag[i] << 1;
         end
         for (int i = 0; i < n; i++) len2 += mag[i] * mag[i];
         s = root_of(len2);
         for (int i = 0; i < n; i++) begin
            q = ((mag[i] << FRAC_BITS) + s / 2) / s;
            o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
         end
      endfunction

      function longint round_frac(longint q);
         longint unsigned m;
         m = q < 0 ? longint'(-q) : q;
         m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
         return q < 0 ? -longint'(m) : longint'(m);
      endfunction

      function logic [47:0] pack(longint v[3]);
         logic [47:0] w;
         for (int i = 0; i < 3; i++) w[i*16 +: 16] = v[i][15:0];
         return w;
      endfunction

      function frame_type frame_of(corner_type c);
         longint p[3][3], uv[3][2], nrm[3];
         longint e1[3], e2[3], d1[3], d2[3], tg[3], bd[3], cr[3], t3[3];
         longint det, adet, dot, thr;
         frame_type f;
         for (int i = 0; i < 3; i++) begin
            p[0][i] = comp(c.corner_pos, i);
            p[1][i] = comp(c.next_pos, i);
            p[2][i] = comp(c.third_pos, i);
            nrm[i]  = comp(c.normal, i);
         end
         for (int i = 0; i < 2; i++) begin
            uv[0][i] = comp(c.corner_uv, i);
            uv[1][i] = comp(c.next_uv, i);
            uv[2][i] = comp(c.third_uv, i);
         end
         for (int i = 0; i < 3; i++) begin
            e1[i] = p[1][i] - p[0][i];
            e2[i] = p[2][i] - p[0][i];
            d1[i] = i < 2 ? uv[1][i] - uv[0][i] : 0;
            d2[i] = i < 2 ? uv[2][i] - uv[0][i] : 0;
         end
         to_unit(e1, 3, t3); e1 = t3;
         to_unit(e2, 3, t3); e2 = t3;
         to_unit(d1, 2, t3); d1 = t3;
         to_unit(d2, 2, t3); d2 = t3;
         det = d1[0] * d2[1] - d1[1] * d2[0];
         adet = det < 0 ? -det : det;
         thr = ((64'd1 << (2 * FRAC_BITS)) + 999999) / 1000000;
         f.degenerate = adet < thr;
         if (f.degenerate) begin
            tg = '{UNIT_ONE, 0, 0};
            bd = '{0, 0, UNIT_ONE};
         end else begin
            for (int i = 0; i < 3; i++) begin
               tg[i] = e1[i] * d2[1] - e2[i] * d1[1];
               bd[i] = e2[i] * d1[0] - e1[i] * d2[0];
               if (det < 0) begin
                  tg[i] = -tg[i];
                  bd[i] = -bd[i];
               end
            end
            to_unit(tg, 3, t3); tg = t3;
            to_unit(bd, 3, t3); bd = t3;
         end
         cr[0] = round_frac(nrm[1] * tg[2] - nrm[2] * tg[1]);
         cr[1] = round_frac(nrm[2] * tg[0] - nrm[0] * tg[2]);
         cr[2] = round_frac(nrm[0] * tg[1] - nrm[1] * tg[0]);
         dot = cr[0] * bd[0] + cr[1] * bd[1] + cr[2] * bd[2];
         f.flipped = dot < 0;
         for (int i = 0; i < 3; i++) begin
            if (f.flipped) cr[i] = -cr[i];
            if (cr[i] > 32767) cr[i] = 32767;
            if (cr[i] < -32768) cr[i] = -32768;
         end
         f.tangent = pack(tg);
         f.bitangent = pack(cr);
         return f;
      endfunction

      function void note_corner(corner_type c);
         frames_due.push_back(frame_of(c));
      endfunction

      function void check_frame(frame_type got);
         frame_type want;
         if (frames_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: %p", got);
            return;
         end
         want = frames_due.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %p, got %p", want, got);
         end
      endfunction

      function int pending();
         return frames_due.size();
      endfunction
   endclass

   logic        clock, reset;
   logic        req_valid, req_stall;
   logic [47:0] req_corner_position, req_next_position, req_third_position;
   logic [31:0] req_corner_uv, req_next_uv, req_third_uv;
   logic [47:0] req_corner_normal;
   logic        rsp_valid, rsp_stall;
   logic [47:0] rsp_tangent_vec, rsp_bitangent_vec;
   logic        rsp_flipped, rsp_degenerate;

   frame_scoreboard_type sb = new();
   bit  no_idle;
   bit  long_hold;
   int  idle_cycles;

   triangle_tangent_frame_core dut (.*);

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   task automatic send_corner(corner_type c);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid           <= 1'b1;
      req_corner_position <= c.corner_pos;
      req_next_position   <= c.next_pos;
      req_third_position  <= c.third_pos;
      req_corner_uv       <= c.corner_uv;
      req_next_uv         <= c.next_uv;
      req_third_uv        <= c.third_uv;
      req_corner_normal   <= c.normal;
      do @(posedge clock); while (req_stall);
      sb.note_corner(c);
   endtask

   function automatic logic [47:0] vec3(int x, int y, int z);
      return {16'(z), 16'(y), 16'(x)};
   endfunction

   function automatic logic [31:0] uv2(int u, int v);
      return {16'(v), 16'(u)};
   endfunction

   function automatic corner_type random_corner();
      corner_type c;
      int axis;
      if ($urandom_range(0, 4) == 0) begin
         c = '{48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
               48'({$urandom, $urandom}), $urandom, $urandom, $urandom,
               48'({$urandom, $urandom})};
         return c;
      end
      c.corner_pos = vec3($urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
                          $urandom_range(0, 4000) - 2000);
      c.next_pos  = vec3($urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
                         $urandom_range(0, 4000) - 2000);
      c.third_pos = vec3($urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
                         $urandom_range(0, 4000) - 2000);
      c.corner_uv = uv2($urandom_range(0, 32000) - 16000, $urandom_range(0, 32000) - 16000);
      c.next_uv   = uv2($urandom_range(0, 32000) - 16000, $urandom_range(0, 32000) - 16000);
      // Now and then the texture coordinates are made collinear.
      if ($urandom_range(0, 9) == 0) c.third_uv = c.next_uv;
      else c.third_uv = uv2($urandom_range(0, 32000) - 16000,
                            $urandom_range(0, 32000) - 16000);
      axis = $urandom_range(0, 3);
      case (axis)
         0: c.normal = vec3($urandom_range(0, 1) ? 16384 : -16384, 0, 0);
         1: c.normal = vec3(0, $urandom_range(0, 1) ? 16384 : -16384, 0);
         2: c.normal = vec3(0, 0, $urandom_range(0, 1) ? 16384 : -16384);
         default: c.normal = vec3($urandom_range(0, 18000) - 9000,
                                  $urandom_range(0, 18000) - 9000,
                                  $urandom_range(0, 18000) - 9000);
      endcase
      return c;
   endfunction

   // Result side: random stall before each word, plus one long hold-off.
   initial begin
      int hold;
      rsp_stall = 1'b1;
      @(negedge reset);
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 14);
         if (long_hold) begin
            hold = 400;
            long_hold = 1'b0;
         end
         repeat (hold) @(negedge clock) rsp_stall <= 1'b1;
         @(negedge clock) rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_frame('{rsp_tangent_vec, rsp_bitangent_vec, rsp_flipped, rsp_degenerate});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == 3000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      corner_type c;
      corner_type directed[$];
      reset = 1'b1;
      req_valid = 1'b0;
      req_corner_position = '0;
      req_next_position = '0;
      req_third_position = '0;
      req_corner_uv = '0;
      req_next_uv = '0;
      req_third_uv = '0;
      req_corner_normal = '0;
      no_idle = 1'b0;
      long_hold = 1'b0;
      idle_cycles = 0;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // All zero gives zero edges and a degenerate determinant.
      directed.push_back('{0, 0, 0, 0, 0, 0, 0});
      directed.push_back('{'1, '1, '1, '1, '1, '1, '1});
      // Plain right triangle, mapped straight and mirrored.
      c = '{vec3(0, 0, 0), vec3(256, 0, 0), vec3(0, 256, 0),
            uv2(0, 0), uv2(8192, 0), uv2(0, 8192), vec3(0, 0, 16384)};
      directed.push_back(c);
      c.third_uv = uv2(0, -8192);
      directed.push_back(c);
      c.normal = vec3(0, 0, -16384);
      directed.push_back(c);
      // Normal components at the range limits force bitangent saturation.
      c.normal = vec3(-32768, -32768, -32768);
      directed.push_back(c);
      c.normal = vec3(32767, 32767, 32767);
      directed.push_back(c);
      // Position extremes in every component.
      directed.push_back('{vec3(-32768, -32768, -32768), vec3(32767, 32767, 32767),
                           vec3(32767, -32768, 0), uv2(-32768, -32768), uv2(32767, 32767),
                           uv2(32767, -32768), vec3(16384, 0, 0)});
      directed.push_back('{vec3(32767, 0, -32768), vec3(-32768, 32767, 0),
                           vec3(0, 0, 0), uv2(32767, -32768), uv2(-32768, 0),
                           uv2(0, 32767), vec3(0, 16384, 0)});
      // Collinear texture coordinates and a tiny but valid determinant.
      directed.push_back('{vec3(0, 0, 0), vec3(100, 0, 0), vec3(0, 100, 0),
                           uv2(0, 0), uv2(100, 100), uv2(200, 200), vec3(0, 0, 16384)});
      directed.push_back('{vec3(0, 0, 0), vec3(100, 0, 0), vec3(0, 100, 0),
                           uv2(0, 0), uv2(16000, 1), uv2(16000, 2), vec3(0, 0, 16384)});
      // Coincident vertices: zero edges with good texture coordinates.
      directed.push_back('{vec3(5, 5, 5), vec3(5, 5, 5), vec3(5, 5, 5),
                           uv2(0, 0), uv2(8192, 0), uv2(0, 8192), vec3(0, 16384, 0)});
      foreach (directed[i]) send_corner(directed[i]);

      // Drain fully before the random part.
      @(negedge clock) req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);

      for (int n = 0; n < 1940; n++) begin
         if (n % 250 == 0) no_idle = $urandom_range(0, 2) == 0;
         if (n == 600) begin
            no_idle = 1'b1;
            long_hold = 1'b1;
         end
         send_corner(random_corner());
      end
      @(negedge clock) req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
